// ----- rtl/core/hrb_pkg.sv -----
// ----------------------------------------------------------------------------
// hrb_pkg: shared types and constants of the HID keyboard report builder
// Keymap entry layout, slot report bundle, command and register codes.
// ----------------------------------------------------------------------------
package hrb_pkg;

  // Keymap storage and report sizing
  localparam int KEYMAP_DEPTH = 128;
  localparam int MAX_SLOTS    = 6;
  localparam int KEYMAP_AW    = (KEYMAP_DEPTH > 1) ? $clog2(KEYMAP_DEPTH) : 1;
  localparam int SCAN_CNT_W   = $clog2(KEYMAP_DEPTH + 1);
  localparam int TOTAL_W      = $clog2(MAX_SLOTS + 1);
  localparam int REPORT_SLOTS = 6;

  // Input commands
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_HIT  = 2'd1;
  localparam logic [1:0] CMD_EOS  = 2'd2;

  // Configuration register indexes
  localparam logic REG_SEARCH_LEN = 1'b0;
  localparam logic REG_ERROR_CODE = 1'b1;

  // Reset value of the rollover error code
  localparam logic [7:0] ERROR_CODE_RST = 8'd1;

  // One keymap entry
  typedef struct packed {
    logic [4:0] col;
    logic [4:0] row;
    logic [7:0] ident;
    logic [7:0] usage;
    logic [7:0] mods;
  } entry_t;

  // Accumulated scan state handed to the report stage
  typedef struct packed {
    logic [TOTAL_W-1:0]              total;
    logic [7:0]                      mods;
    logic                            roll;
    logic [MAX_SLOTS-1:0][7:0]       codes;
  } scan_state_t;

endpackage

// ----- rtl/core/hrb_if.sv -----
// ----------------------------------------------------------------------------
// hrb_if: valid/ready channels of the HID keyboard report builder
// Input item channel and report result channel.
// ----------------------------------------------------------------------------
interface hrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [6:0] entry_index;
  logic [4:0] key_col;
  logic [4:0] key_row;
  logic [7:0] key_ident;
  logic [7:0] hid_usage;
  logic [7:0] modifier_mask;
  logic [7:0] host_leds;

  modport source (
    output valid, command, entry_index, key_col, key_row, key_ident,
           hid_usage, modifier_mask, host_leds,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, key_col, key_row, key_ident,
           hid_usage, modifier_mask, host_leds,
    output ready
  );
endinterface

interface hrb_out_if;
  logic       valid;
  logic       ready;
  logic       send_report;
  logic [7:0] modifiers;
  logic [2:0] key_count;
  logic [7:0] slot0;
  logic [7:0] slot1;
  logic [7:0] slot2;
  logic [7:0] slot3;
  logic [7:0] slot4;
  logic [7:0] slot5;
  logic       rollover;
  logic [2:0] led_state;

  modport source (
    output valid, send_report, modifiers, key_count, slot0, slot1, slot2,
           slot3, slot4, slot5, rollover, led_state,
    input  ready
  );
  modport sink (
    input  valid, send_report, modifiers, key_count, slot0, slot1, slot2,
           slot3, slot4, slot5, rollover, led_state,
    output ready
  );
endinterface

// ----- rtl/core/hrb_keymap.sv -----
// ----------------------------------------------------------------------------
// hrb_keymap: keymap table memory
// One write port for entry loads, one read port with registered data.
// ----------------------------------------------------------------------------
module hrb_keymap
  import hrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [KEYMAP_AW-1:0] wr_addr,
  input  entry_t               wr_data,
  input  logic                 rd_en,
  input  logic [KEYMAP_AW-1:0] rd_addr,
  output entry_t               rd_data
);

  entry_t mem [KEYMAP_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/hrb_slots.sv -----
// ----------------------------------------------------------------------------
// hrb_slots: shared match unit and active key list
// Compares one keymap entry per cycle against the pending hit and updates
// the modifier set, the listed keys and the rollover flag.
// ----------------------------------------------------------------------------
module hrb_slots
  import hrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        chk_valid,
  input  logic [4:0]  hit_col,
  input  logic [4:0]  hit_row,
  input  entry_t      entry,
  input  logic        clear,
  output scan_state_t scan
);

  logic [MAX_SLOTS-1:0][7:0] idents;
  logic [MAX_SLOTS-1:0][7:0] codes;
  logic [TOTAL_W-1:0]        total;
  logic [7:0]                mods;
  logic                      roll;

  logic match;
  logic full;
  logic listed;

  // Position compare and duplicate search over the listed keys
  always_comb begin
    match  = chk_valid && (entry.col == hit_col) && (entry.row == hit_row);
    full   = (32'(total) >= MAX_SLOTS);
    listed = 1'b0;
    for (int k = 0; k < MAX_SLOTS; k++) begin
      if ((32'(k) < 32'(total)) && (idents[k] == entry.ident)) begin
        listed = 1'b1;
      end
    end
  end

  // Control state: count, modifiers, rollover
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      mods  <= '0;
      roll  <= 1'b0;
    end else if (clear) begin
      total <= '0;
      mods  <= '0;
      roll  <= 1'b0;
    end else if (match) begin
      mods <= mods | entry.mods;
      if (full) begin
        roll <= 1'b1;
      end else if (!listed) begin
        total <= total + TOTAL_W'(1);
      end
    end
  end

  // Slot payload: append at the current count
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_SLOTS; k++) begin
      if (match && !full && !listed && (32'(k) == 32'(total))) begin
        idents[k] <= entry.ident;
        codes[k]  <= entry.usage;
      end
    end
  end

  assign scan.total = total;
  assign scan.mods  = mods;
  assign scan.roll  = roll;
  assign scan.codes = codes;

endmodule

// ----- rtl/core/keyboard_hid_report_builder.sv -----
// ----------------------------------------------------------------------------
// keyboard_hid_report_builder: six-key HID keyboard report builder
// Loads a keymap, resolves matrix hits through it and emits one report
// result per end of scan.
// ----------------------------------------------------------------------------
// Load: the entry is written at the transfer; ready stays asserted.
// Key hit: searches the first min(search_len, KEYMAP_DEPTH) entries; the shared match unit
//   checks one keymap entry per cycle through the single memory read port.
// End of scan: the sequencer enters the report state, then the output register is loaded
//   from the scan state once it is free; ready returns when the result is loaded.
// Reset clears the scan state, the sequencer and the output valid, sets search_len to 0 and
//   error_code to 1; keymap is undefined until loaded, with no clearing pass.
module keyboard_hid_report_builder
  import hrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hrb_in_if.sink     in_ch,
  hrb_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  // Sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_REPORT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  logic [7:0] search_len;
  logic [7:0] error_code;

  logic                  in_xfer;
  logic [SCAN_CNT_W-1:0] limit;
  logic [SCAN_CNT_W-1:0] limit_next;
  logic [SCAN_CNT_W-1:0] scan_cnt;
  logic                  issue;
  logic                  chk_valid;
  logic [4:0]            hit_col;
  logic [4:0]            hit_row;
  logic [2:0]            leds;
  logic                  clear_pending;

  entry_t      wr_entry;
  entry_t      rd_entry;
  scan_state_t scan;
  logic        report_load;

  logic                         out_valid;
  logic                         out_send;
  logic [7:0]                   out_mods;
  logic [2:0]                   out_count;
  logic [REPORT_SLOTS-1:0][7:0] out_slots;
  logic                         out_roll;
  logic [2:0]                   out_leds;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_len <= '0;
      error_code <= ERROR_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEARCH_LEN: search_len <= cfg_data;
        REG_ERROR_CODE: error_code <= cfg_data;
        default:        search_len <= search_len;
      endcase
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Number of entries searched, saturated to the table depth
  assign limit_next = (32'(search_len) > KEYMAP_DEPTH) ?
                      SCAN_CNT_W'(KEYMAP_DEPTH) : SCAN_CNT_W'(search_len);

  assign issue       = (state == S_SCAN) && (scan_cnt != limit);
  assign report_load = (state == S_REPORT) && (!out_valid || out_ch.ready);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_ch.command)
            CMD_HIT: state_next = (limit_next != '0) ? S_SCAN : S_IDLE;
            CMD_EOS: state_next = S_REPORT;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_cnt == limit) begin
          state_next = S_IDLE;
        end
      end
      S_REPORT: begin
        if (report_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= issue;
    end
  end

  // Hit position, search bound, entry counter, LED byte
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hit_col  <= in_ch.key_col;
      hit_row  <= in_ch.key_row;
      limit    <= limit_next;
      leds     <= in_ch.host_leds[2:0];
      scan_cnt <= '0;
    end else if (issue) begin
      scan_cnt <= scan_cnt + SCAN_CNT_W'(1);
    end
  end

  // Keymap memory
  assign wr_entry.col   = in_ch.key_col;
  assign wr_entry.row   = in_ch.key_row;
  assign wr_entry.ident = in_ch.key_ident;
  assign wr_entry.usage = in_ch.hid_usage;
  assign wr_entry.mods  = in_ch.modifier_mask;

  hrb_keymap u_keymap (
    .clk     (clk),
    .wr_en   (in_xfer && (in_ch.command == CMD_LOAD) &&
              (32'(in_ch.entry_index) < KEYMAP_DEPTH)),
    .wr_addr (KEYMAP_AW'(in_ch.entry_index)),
    .wr_data (wr_entry),
    .rd_en   (issue),
    .rd_addr (scan_cnt[KEYMAP_AW-1:0]),
    .rd_data (rd_entry)
  );

  // Match unit and active list
  hrb_slots u_slots (
    .clk       (clk),
    .rst       (rst),
    .chk_valid (chk_valid),
    .hit_col   (hit_col),
    .hit_row   (hit_row),
    .entry     (rd_entry),
    .clear     (report_load),
    .scan      (scan)
  );

  // Empty-report tracking after release
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_pending <= 1'b0;
    end else if (report_load) begin
      clear_pending <= (scan.total != '0);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (report_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report_load) begin
      out_leds  <= leds;
      out_send  <= (scan.total != '0) || clear_pending;
      out_mods  <= (scan.total != '0) ? scan.mods : 8'd0;
      out_count <= 3'(scan.total);
      out_roll  <= (scan.total != '0) && scan.roll;
      // slots past the listed keys report zero
      for (int j = 0; j < REPORT_SLOTS; j++) begin
        if (j >= MAX_SLOTS) begin
          out_slots[j] <= 8'd0;
        end
      end
      for (int j = 0; j < MAX_SLOTS; j++) begin
        out_slots[j] <= (32'(j) < 32'(scan.total)) ?
                        (scan.roll ? error_code : scan.codes[j]) : 8'd0;
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.send_report = out_send;
  assign out_ch.modifiers   = out_mods;
  assign out_ch.key_count   = out_count;
  assign out_ch.slot0       = out_slots[0];
  assign out_ch.slot1       = out_slots[1];
  assign out_ch.slot2       = out_slots[2];
  assign out_ch.slot3       = out_slots[3];
  assign out_ch.slot4       = out_slots[4];
  assign out_ch.slot5       = out_slots[5];
  assign out_ch.rollover    = out_roll;
  assign out_ch.led_state   = out_leds;

endmodule
